/* design/crtd_pkg.sv */
// ----------------------------------------------------------------------------
// crtd_pkg
// Shared types, register codes and defaults for the comb reverb with tail
// detection.
// ----------------------------------------------------------------------------
package crtd_pkg;

    localparam int DELAY_DEPTH_DEF = 65536;
    localparam int AVG_SIZE_DEF    = 512;
    localparam int SAMPLE_W        = 16;
    localparam int IDX_W           = 17;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [SAMPLE_W-1:0]        mag_t;
    typedef logic [IDX_W-1:0]           idx_t;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_DELAY  = 2'd1;
    localparam logic [1:0] CFG_GAIN   = 2'd2;
    localparam logic [1:0] CFG_THRESH = 2'd3;

    // mode codes
    localparam logic [1:0] MODE_COMB    = 2'd0;
    localparam logic [1:0] MODE_ECHO    = 2'd1;
    localparam logic [1:0] MODE_LOWPASS = 2'd2;

    // configuration reset values
    localparam logic [1:0]  MODE_RST   = MODE_COMB;
    localparam logic [15:0] DELAY_RST  = 16'd4410;
    localparam logic [15:0] GAIN_RST   = 16'd32768;
    localparam logic [14:0] THRESH_RST = 15'd3;

    localparam idx_t IDX_MAX = '1;

    // payload handed from the compute stage to the tail stage
    typedef struct packed {
        logic    push;
        sample_t y;
        mag_t    mag;
    } calc_t;

endpackage

/* design/crtd_ram.sv */
// ----------------------------------------------------------------------------
// crtd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crtd_ram #(
    parameter int WIDTH = crtd_pkg::SAMPLE_W,
    parameter int DEPTH = crtd_pkg::DELAY_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/comb_reverb_with_tail_detect_core.sv */
// ----------------------------------------------------------------------------
// comb_reverb_with_tail_detect_core
// Comb filter reverb (feedback, feedforward echo, lowpass feedback) with a
// moving-average detector that ends the sound once its tail has decayed.
//
//   channel | signals                                  | transfer when
//   --------+------------------------------------------+---------------------
//   cfg     | cfg_wr_en, cfg_index, cfg_wdata          | cfg_wr_en high
//   in      | in_valid, in_ready, in_sample, start_req | in_valid & in_ready
//   out     | out_valid, out_ready, out_sample, finished | out_valid & out_ready
//
// Each item issues registered tap reads of the history memory in stage A;
// stage B forms the product and does the history write-back, which the
// next item's reads wait for. The window update follows in a third stage.
// rst_n clears configuration and control state; the memories are not cleared,
// and window entries count only once the window has filled.
// A held result stalls the window stage; one more item may wait in the
// compute stage, then in_ready drops. DELAY_DEPTH is a power of two.
// ----------------------------------------------------------------------------
module comb_reverb_with_tail_detect_core #(
    parameter int DELAY_DEPTH = crtd_pkg::DELAY_DEPTH_DEF,
    parameter int AVG_SIZE    = crtd_pkg::AVG_SIZE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  crtd_pkg::sample_t     in_sample,
    input  logic                  start_req,
    output logic                  out_valid,
    input  logic                  out_ready,
    output crtd_pkg::sample_t     out_sample,
    output logic                  finished
);

    localparam int AW    = $clog2(DELAY_DEPTH);
    localparam int MW    = (AW > 16) ? AW : 16;
    localparam int PW    = $clog2(AVG_SIZE);
    localparam int SUM_W = 16 + PW;
    localparam int HW    = 2 * crtd_pkg::SAMPLE_W;

    // configuration
    logic [1:0]  mode_reg;
    logic [15:0] delay_reg;
    logic [15:0] gain_reg;
    logic [14:0] thresh_reg;

    // control state
    logic                 b_valid_reg;
    logic                 c_valid_reg;
    logic                 out_valid_reg;
    logic [AW-1:0]        wp_reg;
    crtd_pkg::idx_t       idx_reg;
    logic [PW-1:0]        ptr_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic                 full_reg;
    logic                 done_reg;

    // payload
    crtd_pkg::sample_t    x_b_reg;
    logic                 start_b_reg;
    crtd_pkg::calc_t      calc_reg;
    crtd_pkg::sample_t    out_sample_reg;
    logic                 finished_reg;

    // stage A
    logic                 in_fire;
    logic [AW-1:0]        wp_a;
    logic [MW-1:0]        m_ext;
    logic [AW-1:0]        m_off;
    logic [AW-1:0]        tap0_addr;
    logic [AW-1:0]        tap1_addr;

    // stage B
    logic                 b_adv;
    logic                 drop_b;
    logic                 hist_we;
    logic [AW-1:0]        wp_b;
    crtd_pkg::idx_t       n_b;
    crtd_pkg::idx_t       m_b;
    crtd_pkg::idx_t       m1_b;
    logic [PW-1:0]        ptr_b;
    logic [HW-1:0]        hist_a_rd;
    crtd_pkg::sample_t    hist_b_rd;
    crtd_pkg::sample_t    x_old;
    crtd_pkg::sample_t    y0;
    crtd_pkg::sample_t    y1;
    logic signed [17:0]   tap_sum;
    logic                 push_b;
    logic signed [34:0]   prod_b;
    logic signed [34:0]   acc_b;
    logic signed [17:0]   y18;
    crtd_pkg::sample_t    y_sat;
    logic [16:0]          y_neg;
    crtd_pkg::mag_t       mag_b;

    // stage C
    logic                 c_fire;
    logic                 win_re;
    logic                 win_we;
    crtd_pkg::mag_t       win_rd;
    crtd_pkg::mag_t       old_c;
    logic [SUM_W-1:0]     sum_c;
    logic [SUM_W-1:0]     thr_scaled;
    logic                 wrap_c;
    logic                 full_c;
    logic                 done_c;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= crtd_pkg::MODE_RST;
            delay_reg  <= crtd_pkg::DELAY_RST;
            gain_reg   <= crtd_pkg::GAIN_RST;
            thresh_reg <= crtd_pkg::THRESH_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                crtd_pkg::CFG_MODE:   mode_reg   <= cfg_wdata[1:0];
                crtd_pkg::CFG_DELAY:  delay_reg  <= cfg_wdata;
                crtd_pkg::CFG_GAIN:   gain_reg   <= cfg_wdata;
                crtd_pkg::CFG_THRESH: thresh_reg <= cfg_wdata[14:0];
                default:              mode_reg   <= mode_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // stage A: accept, issue tap reads
    // ------------------------------------------------------------------------
    assign in_ready  = !b_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign wp_a      = start_req ? '0 : wp_reg;
    assign m_ext     = MW'(delay_reg);
    assign m_off     = m_ext[AW-1:0];
    assign tap0_addr = wp_a - m_off;
    assign tap1_addr = tap0_addr - AW'(1);

    crtd_ram #(
        .WIDTH (HW),
        .DEPTH (DELAY_DEPTH)
    ) u_hist_a (
        .clk     (clk),
        .wr_en   (hist_we),
        .wr_addr (wp_b),
        .wr_data ({x_b_reg, y_sat}),
        .rd_en   (in_fire),
        .rd_addr (tap0_addr),
        .rd_data (hist_a_rd)
    );

    crtd_ram #(
        .WIDTH (crtd_pkg::SAMPLE_W),
        .DEPTH (DELAY_DEPTH)
    ) u_hist_b (
        .clk     (clk),
        .wr_en   (hist_we),
        .wr_addr (wp_b),
        .wr_data (y_sat),
        .rd_en   (in_fire),
        .rd_addr (tap1_addr),
        .rd_data (hist_b_rd)
    );

    // ------------------------------------------------------------------------
    // stage B: comb arithmetic, history write-back
    // ------------------------------------------------------------------------
    assign b_adv   = b_valid_reg && !c_valid_reg;
    assign drop_b  = done_reg && !start_b_reg;
    assign hist_we = b_adv && !drop_b;
    assign wp_b    = start_b_reg ? '0 : wp_reg;
    assign n_b     = start_b_reg ? '0 : idx_reg;
    assign ptr_b   = start_b_reg ? '0 : ptr_reg;
    assign m_b     = {1'b0, delay_reg};
    assign m1_b    = m_b + 17'd1;
    assign x_old   = hist_a_rd[HW-1:crtd_pkg::SAMPLE_W];
    assign y0      = hist_a_rd[crtd_pkg::SAMPLE_W-1:0];
    assign y1      = hist_b_rd;

    always_comb
    begin
        tap_sum = '0;
        push_b  = 1'b1;
        case (mode_reg)
            crtd_pkg::MODE_ECHO:
            begin
                if (n_b >= m_b)
                begin
                    tap_sum = {x_old[15], x_old, 1'b0};
                end
            end
            crtd_pkg::MODE_LOWPASS:
            begin
                if (n_b > m1_b)
                begin
                    tap_sum = {{2{y0[15]}}, y0} + {{2{y1[15]}}, y1};
                end
                else if (n_b == m1_b)
                begin
                    tap_sum = {{2{y0[15]}}, y0};
                end
            end
            default:
            begin
                push_b = (n_b >= m_b);
                if (push_b)
                begin
                    tap_sum = {y0[15], y0, 1'b0};
                end
            end
        endcase
    end

    assign prod_b = $signed({1'b0, gain_reg}) * tap_sum;
    assign acc_b  = prod_b + 35'sd65536 + $signed({{2{x_b_reg[15]}}, x_b_reg, 17'd0});
    assign y18    = acc_b[34:17];

    always_comb
    begin
        if ((y18[17:15] == 3'b000) || (y18[17:15] == 3'b111))
        begin
            y_sat = y18[15:0];
        end
        else if (y18[17])
        begin
            y_sat = 16'sh8000;
        end
        else
        begin
            y_sat = 16'sh7FFF;
        end
    end

    assign y_neg = 17'd0 - {y_sat[15], y_sat};
    assign mag_b = y_sat[15] ? y_neg[15:0] : y_sat;

    // ------------------------------------------------------------------------
    // stage C: moving window and tail decision
    // ------------------------------------------------------------------------
    assign win_re = hist_we && push_b;
    assign c_fire = c_valid_reg && (!out_valid_reg || out_ready);
    assign win_we = c_fire && calc_reg.push;

    crtd_ram #(
        .WIDTH (crtd_pkg::SAMPLE_W),
        .DEPTH (AVG_SIZE)
    ) u_window (
        .clk     (clk),
        .wr_en   (win_we),
        .wr_addr (ptr_reg),
        .wr_data (calc_reg.mag),
        .rd_en   (win_re),
        .rd_addr (ptr_b),
        .rd_data (win_rd)
    );

    assign old_c      = full_reg ? win_rd : '0;
    assign sum_c      = sum_reg - SUM_W'(old_c) + SUM_W'(calc_reg.mag);
    assign thr_scaled = SUM_W'(thresh_reg) * SUM_W'(AVG_SIZE);
    assign wrap_c     = (ptr_reg == PW'(AVG_SIZE - 1));
    assign full_c     = full_reg || wrap_c;
    assign done_c     = calc_reg.push && full_c && (sum_c <= thr_scaled);

    // ------------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            wp_reg        <= '0;
            idx_reg       <= '0;
            ptr_reg       <= '0;
            sum_reg       <= '0;
            full_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                b_valid_reg <= 1'b0;
            end

            if (hist_we)
            begin
                c_valid_reg <= 1'b1;
            end
            else if (c_fire)
            begin
                c_valid_reg <= 1'b0;
            end

            if (c_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (hist_we)
            begin
                wp_reg  <= wp_b + AW'(1);
                idx_reg <= (n_b == crtd_pkg::IDX_MAX) ? n_b : n_b + 17'd1;
            end

            // restart the window on a start transfer, else advance it
            if (hist_we && start_b_reg)
            begin
                ptr_reg  <= '0;
                sum_reg  <= '0;
                full_reg <= 1'b0;
                done_reg <= 1'b0;
            end
            else if (win_we)
            begin
                ptr_reg  <= wrap_c ? '0 : ptr_reg + PW'(1);
                sum_reg  <= sum_c;
                full_reg <= full_c;
                if (done_c)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_b_reg     <= in_sample;
            start_b_reg <= start_req;
        end
        if (hist_we)
        begin
            calc_reg.push <= push_b;
            calc_reg.y    <= y_sat;
            calc_reg.mag  <= mag_b;
        end
        if (c_fire)
        begin
            out_sample_reg <= done_c ? '0 : calc_reg.y;
            finished_reg   <= done_c;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign finished   = finished_reg;

`ifndef SYNTH
    a_finished_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> out_sample == '0)
        else $error("finished result carries a nonzero sample");

    a_done_latched : assert property (@(posedge clk) disable iff (!rst_n)
        c_fire && done_c |=> done_reg)
        else $error("tail decision not held after the finishing transfer");

    a_hist_spacing : assert property (@(posedge clk) disable iff (!rst_n)
        hist_we |=> !hist_we)
        else $error("history written on two consecutive cycles");

    a_full_on_wrap : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full_reg) |-> ptr_reg == '0)
        else $error("window marked full without pointer wrap");
`endif

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the comb reverb with tail detection. A scoreboard
// predicts every output sample and finished flag from the accepted inputs and
// the register settings. Stimulus covers all modes, gain and threshold extremes,
// the shortest delay, saturation, sounds that decay to a finish, broken sounds,
// inputs after a finish, and a closing sound with a mode change and no idling.
// Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int         SETTLE     = 12;
    localparam longint     LIMIT      = 4000000;
    localparam int         ITEM_GOAL  = 960;
    localparam int         WP_W       = $clog2(crtd_pkg::AVG_SIZE_DEF);

    typedef struct {
        crtd_pkg::sample_t y;
        logic              fin;
    } reverb_out_t;

    class comb_tail_sb;
        logic [1:0]        mode;
        int unsigned       delay_m;
        int unsigned       gain;
        int unsigned       thresh;
        crtd_pkg::sample_t out_hist[crtd_pkg::DELAY_DEPTH_DEF];
        crtd_pkg::sample_t in_hist[crtd_pkg::DELAY_DEPTH_DEF];
        int unsigned       sample_n;
        logic [15:0]       wr_pos;
        crtd_pkg::mag_t    win[crtd_pkg::AVG_SIZE_DEF];
        longint            win_sum;
        logic [WP_W-1:0]   win_ptr;
        bit                win_full;
        bit                done;
        reverb_out_t       pending_out[$];
        int                errors;
        int                produced;

        function new();
            mode     = crtd_pkg::MODE_RST;
            delay_m  = 32'(crtd_pkg::DELAY_RST);
            gain     = 32'(crtd_pkg::GAIN_RST);
            thresh   = 32'(crtd_pkg::THRESH_RST);
            sample_n = 0;
            wr_pos   = '0;
            done     = 1'b0;
            errors   = 0;
            produced = 0;
            clear_window();
        endfunction

        function void clear_window();
            foreach (win[i])
                win[i] = '0;
            win_sum  = 0;
            win_ptr  = '0;
            win_full = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] v);
            case (idx)
                crtd_pkg::CFG_MODE:  mode = v[1:0];
                crtd_pkg::CFG_DELAY: delay_m = 32'(v);
                crtd_pkg::CFG_GAIN:  gain = 32'(v);
                default:             thresh = 32'(v[14:0]);
            endcase
        endfunction

        function logic [15:0] tap_at(int unsigned back);
            return wr_pos - back[15:0];
        endfunction

        function longint round_q(longint p, int sh);
            return (p + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        function void accept_sample(crtd_pkg::sample_t x, logic st);
            longint            acc;
            crtd_pkg::sample_t y;
            crtd_pkg::mag_t    mag;
            bit                push;
            reverb_out_t       r;
            if (st)
            begin
                sample_n = 0;
                wr_pos   = '0;
                done     = 1'b0;
                clear_window();
            end
            else if (done)
                return;
            acc  = longint'(x);
            push = 1'b1;
            case (mode)
                crtd_pkg::MODE_ECHO:
                    if (sample_n >= delay_m)
                        acc += round_q(longint'(gain) * longint'(in_hist[tap_at(delay_m)]), 16);
                crtd_pkg::MODE_LOWPASS:
                    if (sample_n > delay_m + 1)
                        acc += round_q(longint'(gain) * (longint'(out_hist[tap_at(delay_m)])
                               + longint'(out_hist[tap_at(delay_m + 1)])), 17);
                    else if (sample_n == delay_m + 1)
                        acc += round_q(longint'(gain) * longint'(out_hist[tap_at(delay_m)]), 17);
                default:
                    if (sample_n >= delay_m)
                        acc += round_q(longint'(gain) * longint'(out_hist[tap_at(delay_m)]), 16);
                    else
                        push = 1'b0;
            endcase
            if (acc > 32767)
                acc = 32767;
            else if (acc < -32768)
                acc = -32768;
            y = crtd_pkg::sample_t'(acc);
            in_hist[wr_pos]  = x;
            out_hist[wr_pos] = y;
            wr_pos++;
            if (sample_n < 32'(crtd_pkg::IDX_MAX))
                sample_n++;
            r.y   = y;
            r.fin = 1'b0;
            if (push)
            begin
                mag = (y < 0) ? crtd_pkg::mag_t'(-y) : crtd_pkg::mag_t'(y);
                win_sum = win_sum - longint'(win[win_ptr]) + longint'(mag);
                win[win_ptr] = mag;
                if (win_ptr == WP_W'(crtd_pkg::AVG_SIZE_DEF - 1))
                begin
                    win_ptr  = '0;
                    win_full = 1'b1;
                end
                else
                    win_ptr++;
                if (win_full &&
                    win_sum <= longint'(thresh) * longint'(crtd_pkg::AVG_SIZE_DEF))
                begin
                    done  = 1'b1;
                    r.y   = '0;
                    r.fin = 1'b1;
                end
            end
            pending_out.push_back(r);
            produced++;
        endfunction

        task flag_mismatch(string msg);
            errors++;
            if (errors <= 100)
                $display("ERROR: %s", msg);
        endtask

        task compare_output(crtd_pkg::sample_t y, logic fin);
            reverb_out_t w;
            if (pending_out.size() == 0)
            begin
                flag_mismatch($sformatf("transfer with nothing pending: out_sample %0d finished %0b",
                              y, fin));
                return;
            end
            w = pending_out.pop_front();
            if (y !== w.y)
                flag_mismatch($sformatf("out_sample got %0d want %0d", y, w.y));
            if (fin !== w.fin)
                flag_mismatch($sformatf("finished got %0b want %0b", fin, w.fin));
        endtask
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [1:0]        cfg_index = crtd_pkg::CFG_MODE;
    logic [15:0]       cfg_wdata = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    crtd_pkg::sample_t in_sample = '0;
    logic              start_req = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    crtd_pkg::sample_t out_sample;
    logic              finished;

    comb_tail_sb sb;
    bit          sender_idle = 1'b0;
    bit          recv_idle   = 1'b0;
    longint      cycles      = 0;

    comb_reverb_with_tail_detect_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_sample  (in_sample),
        .start_req  (start_req),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_sample (out_sample),
        .finished   (finished)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : sink
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.compare_output(out_sample, finished);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (recv_idle && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 12);
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic crtd_pkg::sample_t rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return crtd_pkg::sample_t'(int'($urandom_range(0, 64)) - 32);
            default: return crtd_pkg::sample_t'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] cfg_pick(logic [1:0] idx);
        int r;
        r = $urandom_range(0, 9);
        case (idx)
            crtd_pkg::CFG_MODE:
                return 16'($urandom_range(crtd_pkg::MODE_COMB, MODE_SPARE));
            crtd_pkg::CFG_DELAY:
                return (r == 0) ? 16'd1 : (r < 8) ? 16'($urandom_range(1, 32))
                                                  : 16'($urandom_range(33, 400));
            crtd_pkg::CFG_GAIN:
                return (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 50000));
            default:
                return (r == 0) ? 16'd0 : (r == 1) ? 16'h7FFF : 16'($urandom_range(1, 300));
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] v, input bit last);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        sb.set_reg(idx, v);
        @(posedge clk);
        if (last)
            cfg_wr_en <= 1'b0;
    endtask

    // hold the sender until every pending result has drained
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_config(input logic [15:0] m, input logic [15:0] d,
                               input logic [15:0] g, input logic [15:0] t);
        drain();
        write_reg(crtd_pkg::CFG_MODE, m, 1'b0);
        write_reg(crtd_pkg::CFG_DELAY, d, 1'b0);
        write_reg(crtd_pkg::CFG_GAIN, g, 1'b0);
        write_reg(crtd_pkg::CFG_THRESH, t, 1'b1);
    endtask

    task automatic put_sample(input crtd_pkg::sample_t x, input logic st);
        in_valid  <= 1'b1;
        in_sample <= x;
        start_req <= st;
        do
            @(posedge clk);
        while (!in_ready);
        sb.accept_sample(x, st);
        if (sender_idle && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic play_sound(input bit new_cfg);
        int                burst;
        int                limit;
        int                tweak_at;
        int                k;
        logic [1:0]        idx;
        crtd_pkg::sample_t quiet;
        sender_idle = ($urandom_range(0, 3) != 0);
        recv_idle   = ($urandom_range(0, 3) != 0);
        if (new_cfg)
            load_config(cfg_pick(crtd_pkg::CFG_MODE), cfg_pick(crtd_pkg::CFG_DELAY),
                        cfg_pick(crtd_pkg::CFG_GAIN), cfg_pick(crtd_pkg::CFG_THRESH));
        burst    = $urandom_range(1, 40);
        limit    = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 300) : 1000;
        tweak_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, limit) : -1;
        put_sample(rand_sample(), 1'b1);
        k = 1;
        while (k < limit && !sb.done && sb.produced < ITEM_GOAL)
        begin
            if (k == tweak_at)
            begin
                drain();
                idx = 2'($urandom_range(crtd_pkg::CFG_MODE, crtd_pkg::CFG_THRESH));
                write_reg(idx, cfg_pick(idx), 1'b1);
            end
            quiet = ($urandom_range(0, 15) == 0)
                    ? crtd_pkg::sample_t'(int'($urandom_range(0, 4)) - 2)
                    : crtd_pkg::sample_t'(0);
            put_sample((k < burst) ? rand_sample() : quiet, 1'b0);
            k++;
        end
        if (sb.done)
            repeat ($urandom_range(0, 6)) put_sample(rand_sample(), 1'b0);
    endtask

    initial
    begin : stimulus
        int sounds;
        int k;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        sender_idle = 1'b1;
        recv_idle   = 1'b1;

        // feedback comb: pass-through before the delay, saturation both ways
        load_config(16'(crtd_pkg::MODE_COMB), 16'd1, 16'hFFFF, 16'h7FFF);
        put_sample(16'sh7FFF, 1'b1);
        put_sample(16'sh7FFF, 1'b0);
        put_sample(16'sh8000, 1'b0);
        put_sample(16'sh8000, 1'b0);
        put_sample(16'sh0000, 1'b0);

        // echo with zero gain, then full gain from the next transfer on
        load_config(16'(crtd_pkg::MODE_ECHO), 16'd2, 16'd0, 16'd0);
        put_sample(16'sh8000, 1'b1);
        put_sample(16'sh0001, 1'b0);
        put_sample(-16'sd1, 1'b0);
        put_sample(16'sh7FFF, 1'b0);
        drain();
        write_reg(crtd_pkg::CFG_GAIN, 16'hFFFF, 1'b1);
        put_sample(16'sh7FFF, 1'b0);
        put_sample(16'sh8000, 1'b0);

        // lowpass comb: single tap at n = M+1, then both taps
        load_config(16'(crtd_pkg::MODE_LOWPASS), 16'd1, 16'hFFFF, 16'(crtd_pkg::THRESH_RST));
        put_sample(16'sd100, 1'b1);
        put_sample(16'sd200, 1'b0);
        put_sample(16'sd300, 1'b0);
        put_sample(16'sd400, 1'b0);
        put_sample(16'sh8000, 1'b0);
        put_sample(16'sh7FFF, 1'b0);

        // spare mode code runs as the feedback comb
        load_config(16'(MODE_SPARE), 16'd2, crtd_pkg::GAIN_RST, 16'(crtd_pkg::THRESH_RST));
        put_sample(16'sd5, 1'b1);
        put_sample(16'sd7, 1'b0);
        put_sample(-16'sd3, 1'b0);
        put_sample(16'sd1, 1'b0);

        sounds = 0;
        while (sb.produced < ITEM_GOAL && sounds < 40)
        begin
            play_sound(sounds == 0 || $urandom_range(0, 2) == 0);
            sounds++;
        end

        // closing sound with no idling, then a switch to the lowpass comb
        sender_idle = 1'b0;
        recv_idle   = 1'b0;
        load_config(16'(crtd_pkg::MODE_COMB), 16'd40, 16'($urandom_range(0, 65535)), 16'd0);
        put_sample(rand_sample(), 1'b1);
        for (k = 1; k < 120; k++)
            put_sample(rand_sample(), 1'b0);
        drain();
        write_reg(crtd_pkg::CFG_MODE, 16'(crtd_pkg::MODE_LOWPASS), 1'b1);
        for (k = 0; k < 100; k++)
            put_sample(rand_sample(), 1'b0);

        drain();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
